// ===== rtl/ord_pkg.sv =====
// shared types, constants and helper functions for the output-restricted deque
package ord_pkg;

  localparam int DEPTH     = 8;
  localparam int DATA_BITS = 32;
  localparam int SLOT_BITS = $clog2(DEPTH);

  typedef enum logic [1:0] {
    REQ_INS_HEAD = 2'd0,
    REQ_INS_TAIL = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_DUMP     = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_value;
    logic [2:0]         slot_index;
    logic               last_flag;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic capture_read;
    logic advance;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read;
    logic dump_more;
  } ctl_stat_t;

  function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] s);
    logic [SLOT_BITS-1:0] r;
    if (s == SLOT_BITS'(DEPTH - 1)) r = '0;
    else r = s + SLOT_BITS'(1);
    return r;
  endfunction

  function automatic logic [SLOT_BITS-1:0] prev_slot(input logic [SLOT_BITS-1:0] s);
    logic [SLOT_BITS-1:0] r;
    if (s == '0) r = SLOT_BITS'(DEPTH - 1);
    else r = s - SLOT_BITS'(1);
    return r;
  endfunction

  // keep the low DATA_BITS of the sign-extended input value
  function automatic logic [DATA_BITS-1:0] to_store(input logic signed [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_BITS-1:0];
  endfunction

  // sign-extend a stored value and keep its low 32 bits
  function automatic logic [31:0] from_store(input logic [DATA_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(signed'(v));
    return w[31:0];
  endfunction

  function automatic logic [2:0] slot_out(input logic [SLOT_BITS-1:0] s);
    logic [63:0] w;
    w = 64'(s);
    return w[2:0];
  endfunction

endpackage

// ===== rtl/ord_ctrl.sv =====
// controller state machine: sequences accept, memory read and result hand-off
module ord_ctrl import ord_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.needs_read ? S_READ : S_SEND;
        end
      end
      S_READ: begin
        cmd.capture_read = 1'b1;
        state_nxt        = S_SEND;
      end
      S_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (stat.dump_more) begin
            // fetch the next entry of the dump
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ord_dp.sv =====
// datapath: entry memory, head/tail pointers, dump cursor and result register
module ord_dp import ord_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  output out_item_t out_data,
  input  ctl_cmd_t  cmd,
  output ctl_stat_t stat
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  logic [SLOT_BITS-1:0] head_r, head_nxt;
  logic [SLOT_BITS-1:0] tail_r, tail_nxt;
  logic                 empty_r, empty_nxt;
  logic [SLOT_BITS-1:0] cur_r, cur_nxt;
  logic [SLOT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]           kind_r, kind_nxt;
  out_item_t            out_r, out_nxt;
  logic [DATA_BITS-1:0] rd_data_r;

  logic                 wr_en;
  logic [SLOT_BITS-1:0] wr_addr;
  logic                 full;
  logic                 dump_last;

  assign full      = !empty_r && (next_slot(tail_r) == head_r);
  assign dump_last = (cur_r == tail_r) || (cnt_r == SLOT_BITS'(DEPTH - 1));

  assign stat.needs_read = ((in_data.req_type == REQ_REMOVE) ||
                            (in_data.req_type == REQ_DUMP)) && !empty_r;
  assign stat.dump_more  = (kind_r == REQ_DUMP) && !out_r.last_flag;

  assign out_data = out_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    out_nxt   = out_r;
    wr_en     = 1'b0;
    wr_addr   = '0;

    if (cmd.accept) begin
      kind_nxt = in_data.req_type;
      cur_nxt  = head_r;
      cnt_nxt  = '0;
      out_nxt  = '{status: ST_OK, data_value: '0, slot_index: '0, last_flag: 1'b1};
      if ((in_data.req_type == REQ_INS_HEAD) || (in_data.req_type == REQ_INS_TAIL)) begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = '0;
        end else if (in_data.req_type == REQ_INS_HEAD) begin
          head_nxt = prev_slot(head_r);
          wr_en    = 1'b1;
          wr_addr  = prev_slot(head_r);
        end else begin
          tail_nxt = next_slot(tail_r);
          wr_en    = 1'b1;
          wr_addr  = next_slot(tail_r);
        end
      end else if (empty_r) begin
        out_nxt.status = ST_EMPTY;
      end
    end

    if (cmd.capture_read) begin
      if (kind_r == REQ_DUMP) begin
        out_nxt = '{status: ST_OK, data_value: from_store(rd_data_r),
                    slot_index: slot_out(cur_r), last_flag: dump_last};
      end else begin
        out_nxt = '{status: ST_OK, data_value: from_store(rd_data_r),
                    slot_index: '0, last_flag: 1'b1};
        // removing the only entry returns both pointers to slot zero
        if (head_r == tail_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b1;
        end else begin
          head_nxt = next_slot(head_r);
        end
      end
    end

    if (cmd.advance) begin
      cur_nxt = next_slot(cur_r);
      cnt_nxt = cnt_r + SLOT_BITS'(1);
    end
  end

  // memory write and registered read at the cursor
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= to_store(in_data.item_value);
    end
    rd_data_r <= mem[cur_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    cnt_r  <= cnt_nxt;
    kind_r <= kind_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== rtl/output_restricted_deque_top.sv =====
// top level of the output-restricted deque: controller plus datapath
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_item_t  (req_type, item_value)
//   out      output     out_valid/out_stall out_item_t (status, data_value,
//                                                       slot_index, last_flag)
//
// an insert, or a remove/dump of an empty deque, shows its result in the cycle after
// the transaction; a remove of a stored entry passes through S_READ first, for the
// registered entry-memory read. a dump passes through S_READ and S_SEND for each
// entry, using that same read port. a new request is taken the cycle after the last
// result of the previous one leaves. synchronous active-low reset empties the deque; a
// stalled result holds in the output register until taken.
module output_restricted_deque_top import ord_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  ord_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ord_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the output-restricted deque with a scoreboard class
module tb;
  import ord_pkg::*;

  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_ITEMS   = 380;

  // tracks the deque contents and the results each request should produce
  class deque_scoreboard;
    logic [31:0] slot_val [DEPTH];
    int          front;
    int          rear;
    bit          empty;
    out_item_t   pending_results[$];
    int unsigned errs;

    function new();
      front = 0;
      rear  = 0;
      empty = 1'b1;
      errs  = 0;
    endfunction

    function int step_fwd(int s);
      return (s == DEPTH - 1) ? 0 : s + 1;
    endfunction

    function int step_back(int s);
      return (s == 0) ? DEPTH - 1 : s - 1;
    endfunction

    function void note_request(in_item_t r);
      out_item_t e;
      int        s;
      int        n;
      bit        done;
      e = '0;
      e.last_flag = 1'b1;
      case (r.req_type)
        REQ_INS_HEAD, REQ_INS_TAIL: begin
          if (!empty && step_fwd(rear) == front) begin
            e.status = ST_FULL;
          end else begin
            if (empty) begin
              front = 0;
              rear = 0;
              empty = 1'b0;
              slot_val[0] = r.item_value;
            end else if (r.req_type == REQ_INS_HEAD) begin
              front = step_back(front);
              slot_val[front] = r.item_value;
            end else begin
              rear = step_fwd(rear);
              slot_val[rear] = r.item_value;
            end
            e.status = ST_OK;
          end
          pending_results.push_back(e);
        end
        REQ_REMOVE: begin
          if (empty) begin
            e.status = ST_EMPTY;
          end else begin
            e.status = ST_OK;
            e.data_value = slot_val[front];
            if (front == rear) begin
              front = 0;
              rear = 0;
              empty = 1'b1;
            end else begin
              front = step_fwd(front);
            end
          end
          pending_results.push_back(e);
        end
        default: begin
          if (empty) begin
            e.status = ST_EMPTY;
            pending_results.push_back(e);
          end else begin
            s = front;
            n = 0;
            done = 1'b0;
            while (!done) begin
              e.status = ST_OK;
              e.data_value = slot_val[s];
              e.slot_index = 3'(s);
              done = (s == rear) || (n == DEPTH - 1);
              e.last_flag = done;
              pending_results.push_back(e);
              n++;
              s = step_fwd(s);
            end
          end
        end
      endcase
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, field, got, want);
      errs++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report("unexpected transaction", 32'(got), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.data_value !== want.data_value)
          report("data_value", got.data_value, want.data_value);
        if (got.slot_index !== want.slot_index)
          report("slot_index", 32'(got.slot_index), 32'(want.slot_index));
        if (got.last_flag !== want.last_flag)
          report("last_flag", 32'(got.last_flag), 32'(want.last_flag));
      end
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  deque_scoreboard sb;
  bit calm;
  bit hold_req;

  output_restricted_deque_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // offer one request, idling first at random, and hold it until taken
  task automatic send_request(input logic [1:0] kind, input logic [31:0] value);
    in_item_t r;
    r.req_type = kind;
    r.item_value = value;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end
    return v;
  endfunction

  function automatic logic [1:0] pick_kind(bit filling);
    int pick;
    pick = $urandom_range(99);
    if (filling) begin
      if (pick < 38) return REQ_INS_HEAD;
      if (pick < 76) return REQ_INS_TAIL;
      if (pick < 90) return REQ_REMOVE;
      return REQ_DUMP;
    end
    if (pick < 12) return REQ_INS_HEAD;
    if (pick < 24) return REQ_INS_TAIL;
    if (pick < 82) return REQ_REMOVE;
    return REQ_DUMP;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    bit filling;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty deque, single entry in and out, then fill to full
    send_request(REQ_DUMP, 32'h0);
    send_request(REQ_REMOVE, 32'hffff_ffff);
    send_request(REQ_INS_HEAD, 32'h7fff_ffff);
    send_request(REQ_REMOVE, 32'h0);
    send_request(REQ_INS_TAIL, 32'h8000_0000);
    send_request(REQ_INS_HEAD, 32'hffff_ffff);
    send_request(REQ_INS_HEAD, 32'h0000_0000);
    send_request(REQ_INS_TAIL, 32'h5555_5555);
    send_request(REQ_INS_TAIL, 32'haaaa_aaaa);
    send_request(REQ_INS_HEAD, 32'h0000_0001);
    send_request(REQ_INS_TAIL, 32'h1234_5678);
    send_request(REQ_INS_HEAD, 32'hfedc_ba98);
    // full: both inserts rejected, dump gives every slot
    send_request(REQ_INS_HEAD, 32'hdead_beef);
    send_request(REQ_INS_TAIL, 32'hcafe_f00d);
    send_request(REQ_DUMP, 32'hffff_ffff);
    repeat (DEPTH) send_request(REQ_REMOVE, 32'h0);
    send_request(REQ_REMOVE, 32'h0);
    send_request(REQ_DUMP, 32'h0);

    filling = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 24 == 0) filling = !filling;
      if (i == 120) begin
        // let every outstanding result drain before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
      end
      if (i == 200) hold_req = 1'b1;
      calm = (i >= 250 && i < 320);
      send_request(pick_kind(filling), pick_value());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errs == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== output_restricted_deque_top.f =====
rtl/ord_pkg.sv
rtl/ord_ctrl.sv
rtl/ord_dp.sv
rtl/output_restricted_deque_top.sv
bench/tb.sv
